### sv/a64x_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// a64x_pkg
// Shared types and constants for the AArch64 subset execute unit.
// ----------------------------------------------------------------------------
package a64x_pkg;

    localparam int unsigned XLEN     = 64;
    localparam int unsigned NUM_REGS = 31;

    // instruction groups
    localparam logic [1:0] FUNC_DPI = 2'd0;
    localparam logic [1:0] FUNC_DPR = 2'd1;
    localparam logic [1:0] FUNC_BR  = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_ENC   = 2'd1;
    localparam logic [1:0] ST_COND  = 2'd2;
    localparam logic [1:0] ST_BRZR  = 2'd3;

    // condition codes
    localparam logic [3:0] CC_EQ = 4'h0;
    localparam logic [3:0] CC_NE = 4'h1;
    localparam logic [3:0] CC_GE = 4'hA;
    localparam logic [3:0] CC_LT = 4'hB;
    localparam logic [3:0] CC_GT = 4'hC;
    localparam logic [3:0] CC_LE = 4'hD;
    localparam logic [3:0] CC_AL = 4'hE;

    localparam logic [3:0] FLAGS_RESET = 4'h4;

    // operands read from the register file for one instruction
    typedef struct packed {
        logic [XLEN-1:0] rn;
        logic [XLEN-1:0] rm;
        logic [XLEN-1:0] ra;
        logic [XLEN-1:0] rd;
    } t_operands;

    // result of one instruction
    typedef struct packed {
        logic            reg_write;
        logic [4:0]      dest_index;
        logic [XLEN-1:0] write_value;
        logic [3:0]      flags;
        logic [XLEN-1:0] next_pc;
        logic [1:0]      status;
    } t_result;

endpackage

### sv/a64x_regfile.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// a64x_regfile
// General registers with four combinational read ports; index 31 reads zero.
// ----------------------------------------------------------------------------
module a64x_regfile
    import a64x_pkg::*;
#(
    parameter int unsigned P_NUM_REGS = NUM_REGS
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_we,
    input  logic [4:0]      i_waddr,
    input  logic [XLEN-1:0] i_wdata,
    input  logic [4:0]      i_ra_n,
    input  logic [4:0]      i_ra_m,
    input  logic [4:0]      i_ra_a,
    input  logic [4:0]      i_ra_d,
    output t_operands       o_ops
);

    logic [XLEN-1:0] r_regs [P_NUM_REGS];

    // write port; reset clears every register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < int'(P_NUM_REGS); i++) r_regs[i] <= '0;
        end else if (i_we && (32'(i_waddr) < P_NUM_REGS)) begin
            r_regs[i_waddr] <= i_wdata;
        end
    end

    function automatic logic [XLEN-1:0] rd_port(input logic [4:0] a);
        logic [XLEN-1:0] v;
        v = '0;
        for (int i = 0; i < int'(P_NUM_REGS); i++) begin
            if (32'(a) == i) v = r_regs[i];
        end
        return v;
    endfunction

    always_comb begin
        o_ops.rn = rd_port(i_ra_n);
        o_ops.rm = rd_port(i_ra_m);
        o_ops.ra = rd_port(i_ra_a);
        o_ops.rd = rd_port(i_ra_d);
    end

endmodule

### sv/a64x_exec.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// a64x_exec
// Combinational decode and execute of one instruction word.
// ----------------------------------------------------------------------------
module a64x_exec
    import a64x_pkg::*;
(
    input  logic [1:0]      i_func,
    input  logic [31:0]     i_insn,
    input  t_operands       i_ops,
    input  logic [3:0]      i_flags,
    input  logic [XLEN-1:0] i_pc,
    output t_result         o_res
);

    logic            sf, wr, take, cond_ok;
    logic [1:0]      opc, status, hw;
    logic [2:0]      opi;
    logic [3:0]      opr, fl, cond;
    logic [5:0]      amt;
    logic [1:0]      kind;
    logic [4:0]      rd;
    logic [XLEN-1:0] m, val, npc, a, b, op, sres, ia, ib, sum, pm;
    logic [XLEN:0]   ext;
    logic            sub, setf, n, z, c, v;
    logic            fn, fz, fv;
    logic [6:0]      wd, ramt;
    logic [XLEN-1:0] mul_a, mul_b, p_ll;
    logic [31:0]     p_lh, p_hl;

    always_comb begin
        sf     = i_insn[31];
        opc    = i_insn[30:29];
        rd     = i_insn[4:0];
        m      = sf ? '1 : 64'h0000_0000_FFFF_FFFF;
        wd     = sf ? 7'd64 : 7'd32;
        opi    = i_insn[25:23];
        opr    = i_insn[24:21];
        amt    = i_insn[15:10];
        kind   = opr[2:1];
        hw     = i_insn[22:21];
        cond   = i_insn[3:0];
        status = ST_OK;
        wr     = 1'b0;
        val    = '0;
        fl     = i_flags;
        npc    = i_pc + 64'd4;
        a      = '0;
        b      = '0;
        op     = '0;
        sres   = '0;
        sub    = 1'b0;
        setf   = 1'b0;
        ia     = '0;
        ib     = '0;
        pm     = '0;
        ramt   = '0;
        {fn, fz, fv} = {i_flags[3], i_flags[2], i_flags[0]};

        // low 64 bits of the product from 32x32 partial products
        mul_a = i_ops.rm & m;
        mul_b = i_ops.rn & m;
        p_ll  = 64'(mul_a[31:0]) * 64'(mul_b[31:0]);
        p_lh  = mul_a[31:0] * mul_b[63:32];
        p_hl  = mul_a[63:32] * mul_b[31:0];

        // shifter for register forms
        b = i_ops.rm & m;
        if (amt != 6'd0) begin
            case (kind)
                2'd0: sres = (b << amt) & m;
                2'd1: sres = b >> amt;
                2'd2: sres = sf ? 64'($signed(b) >>> amt)
                                : 64'($unsigned(32'($signed(b[31:0]) >>> amt)));
                default: begin
                    ramt = wd - 7'(amt);
                    sres = ((b >> amt) | (b << ramt)) & m;
                end
            endcase
        end else begin
            sres = b;
        end

        // operand selection for the shared adder
        case (i_func)
            FUNC_DPI: begin
                ia = i_ops.rn & m;
                ib = (i_insn[22] ? {40'd0, i_insn[21:10], 12'd0}
                                 : {52'd0, i_insn[21:10]}) & m;
            end
            default: begin
                ia = i_ops.rn & m;
                ib = sres;
            end
        endcase
        sub  = opc[1];
        setf = opc[0];
        ext  = {1'b0, ia} + {1'b0, (sub ? ~ib & m : ib)} + {64'd0, sub};
        sum  = ext[XLEN-1:0] & m;
        c    = sf ? ext[XLEN] : ext[32];
        n    = sf ? sum[63] : sum[31];
        z    = (sum == '0);
        v    = sf ? ((ia[63] ^ sum[63]) & ~(ia[63] ^ ib[63] ^ sub))
                  : ((ia[31] ^ sum[31]) & ~(ia[31] ^ ib[31] ^ sub));

        // condition evaluation
        cond_ok = 1'b1;
        unique case (cond)
            CC_EQ:   take = fz;
            CC_NE:   take = !fz;
            CC_GE:   take = (fn == fv);
            CC_LT:   take = (fn != fv);
            CC_GT:   take = !fz && (fn == fv);
            CC_LE:   take = !(!fz && (fn == fv));
            CC_AL:   take = 1'b1;
            default: begin
                take    = 1'b0;
                cond_ok = 1'b0;
            end
        endcase

        unique case (i_func)
            FUNC_DPI: begin
                if (opi == 3'd2) begin
                    val = sum;
                    wr  = 1'b1;
                    if (setf) fl = {n, z, c, v};
                end else if (opi == 3'd5) begin
                    op = {48'd0, i_insn[20:5]} << {hw, 4'd0};
                    if (opc == 2'd1 || (!sf && hw[1])) begin
                        status = ST_ENC;
                    end else begin
                        wr = 1'b1;
                        case (opc)
                            2'd0:    val = ~op & m;
                            2'd2:    val = op & m;
                            default: val = ((i_ops.rd &
                                       ~(64'h0000_0000_0000_FFFF << {hw, 4'd0})) | op) & m;
                        endcase
                    end
                end else begin
                    status = ST_ENC;
                end
            end
            FUNC_DPR: begin
                if (!i_insn[28] && ((opr | 4'h6) == 4'hE || !opr[3])) begin
                    if (7'(amt) >= wd) begin
                        status = ST_ENC;
                    end else begin
                        wr = 1'b1;
                        if (opr[3]) begin
                            val = sum;
                            if (setf) fl = {n, z, c, v};
                        end else begin
                            a = i_ops.rn & m;
                            b = opr[0] ? ~sres & m : sres;
                            case (opc)
                                2'd1:    val = a | b;
                                2'd2:    val = a ^ b;
                                default: val = a & b;
                            endcase
                            if (opc == 2'd3)
                                fl = {(sf ? val[63] : val[31]), (val == '0), 2'b00};
                        end
                    end
                end else if (i_insn[28] && opr == 4'h8) begin
                    pm  = p_ll + {p_lh + p_hl, 32'd0};
                    val = (i_insn[15] ? (i_ops.ra & m) - pm : (i_ops.ra & m) + pm) & m;
                    wr  = 1'b1;
                end else begin
                    status = ST_ENC;
                end
            end
            FUNC_BR: begin
                case (i_insn[31:30])
                    2'd0: npc = i_pc + {{36{i_insn[25]}}, i_insn[25:0], 2'b00};
                    2'd1: begin
                        if (!cond_ok) status = ST_COND;
                        else if (take)
                            npc = i_pc + {{43{i_insn[23]}}, i_insn[23:5], 2'b00};
                    end
                    2'd3: begin
                        if (i_insn[9:5] == 5'd31) status = ST_BRZR;
                        else npc = i_ops.rn;
                    end
                    default: status = ST_ENC;
                endcase
            end
            default: status = ST_ENC;
        endcase

        if (status != ST_OK) begin
            wr  = 1'b0;
            fl  = i_flags;
            npc = i_pc;
        end
        if (rd == 5'd31) wr = 1'b0;

        o_res.reg_write   = wr;
        o_res.dest_index  = wr ? rd : 5'd0;
        o_res.write_value = wr ? val : '0;
        o_res.flags       = fl;
        o_res.next_pc     = npc;
        o_res.status      = status;
    end

endmodule

### sv/aarch64_subset_execute_unit.sv
`timescale 1ns / 1ps
// A word's result is registered into the output slot at the edge that accepts it.
// Throughput: one word per cycle while the output slot can take it; the register
// file, flags and PC update at the accept edge, so the next word sees them at once.
// The output register is a skid-free slot: input is taken when it is empty or drained.
// Reset (synchronous, active low) clears registers, PC, output valid; flags = Z.
// ----------------------------------------------------------------------------
// aarch64_subset_execute_unit
// Single-pass execute of an AArch64 subset with architectural state.
// ----------------------------------------------------------------------------
module aarch64_subset_execute_unit
    import a64x_pkg::*;
#(
    parameter int unsigned P_NUM_REGS = NUM_REGS
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [31:0]  s_axis_tdata,  // instruction_word
    input  logic [1:0]   s_axis_tuser,  // func
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [143:0] m_axis_tdata   // reg_write, dest_index[5], write_value[64],
                                        // flags_nzcv[4], next_pc[64], status[2], zero pad
);

    logic            r_valid;
    t_result         r_res, n_res;
    logic [3:0]      r_flags;
    logic [XLEN-1:0] r_pc;
    t_operands       ops;
    logic            acc;

    assign s_axis_tready = !r_valid || m_axis_tready;
    assign acc           = s_axis_tvalid && s_axis_tready;

    a64x_regfile #(.P_NUM_REGS(P_NUM_REGS)) u_rf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (acc && n_res.reg_write),
        .i_waddr (n_res.dest_index),
        .i_wdata (n_res.write_value),
        .i_ra_n  (s_axis_tdata[9:5]),
        .i_ra_m  (s_axis_tdata[20:16]),
        .i_ra_a  (s_axis_tdata[14:10]),
        .i_ra_d  (s_axis_tdata[4:0]),
        .o_ops   (ops)
    );

    a64x_exec u_exec (
        .i_func  (s_axis_tuser),
        .i_insn  (s_axis_tdata),
        .i_ops   (ops),
        .i_flags (r_flags),
        .i_pc    (r_pc),
        .o_res   (n_res)
    );

    // architectural flags and PC, output slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_flags <= FLAGS_RESET;
            r_pc    <= '0;
        end else begin
            if (acc) begin
                r_valid <= 1'b1;
                r_flags <= n_res.flags;
                r_pc    <= n_res.next_pc;
            end else if (m_axis_tready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) r_res <= n_res;
    end

    assign m_axis_tvalid = r_valid;
    assign m_axis_tdata  = {4'd0, r_res.status, r_res.next_pc, r_res.flags,
                            r_res.write_value, r_res.dest_index, r_res.reg_write};

endmodule

### tb/sv/aarch64_subset_execute_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aarch64_subset_execute_unit_test
// Self-checking bench for the execute unit: a directed table of instruction
// words, then random instruction streams, each result checked field by field
// against the table entry or an architectural model of registers, flags and PC.
// ----------------------------------------------------------------------------
module aarch64_subset_execute_unit_test;
    import a64x_pkg::*;

    localparam int LIMIT_CYCLES = 400000;
    localparam int N_RANDOM     = 1630;

    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] insn;
    } t_word;

    typedef struct {
        t_word word;
        bit    known;
        t_result res;
    } t_row;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [31:0]  s_axis_tdata = '0;   // instruction_word
    logic [1:0]   s_axis_tuser = '0;   // func
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [143:0] m_axis_tdata;        // reg_write, dest_index, write_value, flags,
                                       // next_pc, status, pad

    aarch64_subset_execute_unit DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always #1 i_clk = ~i_clk;

    // model state
    logic [63:0] arch_regs [NUM_REGS];
    logic [3:0]  arch_flags;
    logic [63:0] arch_pc;

    t_result pending_results[$];
    t_row    rows[$];
    int      errors = 0;
    int      cycles = 0;
    bit      calm = 1'b0;        // no idling in the tail
    bit      hold_long = 1'b0;   // request a long receiver stall

    function automatic logic [63:0] rd_reg(logic [4:0] idx);
        return (idx == 5'd31) ? 64'd0 : arch_regs[idx];
    endfunction

    function automatic logic [63:0] wmask(bit sf);
        return sf ? '1 : 64'hFFFF_FFFF;
    endfunction

    function automatic logic [63:0] shift_op(logic [63:0] v, logic [1:0] kind,
                                             int amt, bit sf);
        logic [63:0] m;
        int w;
        m = wmask(sf);
        w = sf ? 64 : 32;
        v &= m;
        if (amt == 0) return v;
        case (kind)
            2'd0: return (v << amt) & m;
            2'd1: return v >> amt;
            2'd2: return (v >> amt) | (v[w-1] ? (m ^ (m >> amt)) : 64'd0);
            default: return ((v >> amt) | (v << (w - amt))) & m;
        endcase
    endfunction

    function automatic logic [63:0] add_sub(logic [63:0] a, logic [63:0] b, bit sub,
                                            bit setf, bit sf, inout logic [3:0] fl);
        logic [63:0] m, r;
        bit c, v;
        int w;
        m = wmask(sf);
        w = sf ? 64 : 32;
        a &= m;
        b &= m;
        if (sub) begin
            r = (a - b) & m;
            c = a >= b;
            v = 1'(((a ^ b) & (a ^ r)) >> (w - 1));
        end else begin
            r = (a + b) & m;
            c = r < a;
            v = 1'(((~(a ^ b)) & (a ^ r)) >> (w - 1));
        end
        if (setf) fl = {r[w-1], r == 64'd0, c, v};
        return r;
    endfunction

    // Executes one word on the architectural model and returns its result.
    function automatic t_result execute_word(t_word wd);
        t_result o;
        logic [31:0] w;
        logic [3:0] fl;
        logic [63:0] npc, val, m, op, a, b, off;
        logic [1:0] st;
        bit wr, sf, ok, take;
        logic [1:0] opc;
        logic [3:0] opr;
        logic [4:0] rd;
        int amt, hw;
        w = wd.insn;
        fl = arch_flags;
        npc = arch_pc + 64'd4;
        st = ST_OK;
        wr = 1'b0;
        val = '0;
        rd = w[4:0];
        sf = w[31];
        opc = w[30:29];
        m = wmask(sf);
        if (wd.func == FUNC_DPI) begin
            if (w[25:23] == 3'd2) begin
                op = 64'(w[21:10]) << (w[22] ? 12 : 0);
                val = add_sub(rd_reg(w[9:5]), op, opc[1], opc[0], sf, fl);
                wr = 1'b1;
            end else if (w[25:23] == 3'd5) begin
                hw = int'(w[22:21]);
                op = 64'(w[20:5]) << (hw * 16);
                if (opc == 2'd1 || (!sf && hw > 1)) begin
                    st = ST_ENC;
                end else begin
                    if (opc == 2'd0) val = ~op & m;
                    else if (opc == 2'd2) val = op & m;
                    else val = ((rd_reg(rd) & ~(64'hFFFF << (hw * 16))) | op) & m;
                    wr = 1'b1;
                end
            end else begin
                st = ST_ENC;
            end
        end else if (wd.func == FUNC_DPR) begin
            opr = w[24:21];
            amt = int'(w[15:10]);
            if (!w[28] && ((opr | 4'd6) == 4'hE || !opr[3])) begin
                if (amt >= (sf ? 64 : 32)) begin
                    st = ST_ENC;
                end else begin
                    a = rd_reg(w[9:5]) & m;
                    b = shift_op(rd_reg(w[20:16]), opr[2:1], amt, sf);
                    if (opr[3]) begin
                        val = add_sub(a, b, opc[1], opc[0], sf, fl);
                    end else begin
                        if (opr[0]) b = ~b & m;
                        if (opc == 2'd1) val = a | b;
                        else if (opc == 2'd2) val = a ^ b;
                        else val = a & b;
                        if (opc == 2'd3) fl = {sf ? val[63] : val[31], val == 64'd0, 2'b00};
                    end
                    wr = 1'b1;
                end
            end else if (w[28] && opr == 4'd8) begin
                a = (rd_reg(w[20:16]) & m) * (rd_reg(w[9:5]) & m);
                val = (w[15] ? (rd_reg(w[14:10]) & m) - a : (rd_reg(w[14:10]) & m) + a) & m;
                wr = 1'b1;
            end else begin
                st = ST_ENC;
            end
        end else if (wd.func == FUNC_BR) begin
            case (w[31:30])
                2'd0: begin
                    off = {{38{w[25]}}, w[25:0]};
                    npc = arch_pc + (off << 2);
                end
                2'd1: begin
                    ok = 1'b1;
                    case (w[3:0])
                        CC_EQ: take = fl[2];
                        CC_NE: take = !fl[2];
                        CC_GE: take = fl[3] == fl[0];
                        CC_LT: take = fl[3] != fl[0];
                        CC_GT: take = !fl[2] && fl[3] == fl[0];
                        CC_LE: take = !(!fl[2] && fl[3] == fl[0]);
                        CC_AL: take = 1'b1;
                        default: begin ok = 1'b0; take = 1'b0; end
                    endcase
                    off = {{45{w[23]}}, w[23:5]};
                    if (!ok) st = ST_COND;
                    else if (take) npc = arch_pc + (off << 2);
                end
                2'd3: begin
                    if (w[9:5] == 5'd31) st = ST_BRZR;
                    else npc = rd_reg(w[9:5]);
                end
                default: st = ST_ENC;
            endcase
        end else begin
            st = ST_ENC;
        end
        // any error leaves the architectural state alone
        if (st != ST_OK) begin
            wr = 1'b0;
            fl = arch_flags;
            npc = arch_pc;
        end
        if (rd == 5'd31) wr = 1'b0;
        if (wr) arch_regs[rd] = val;
        else begin
            rd = '0;
            val = '0;
        end
        arch_flags = fl;
        arch_pc = npc;
        o.reg_write = wr;
        o.dest_index = rd;
        o.write_value = val;
        o.flags = fl;
        o.next_pc = npc;
        o.status = st;
        return o;
    endfunction

    function automatic t_result res_of(bit w, logic [4:0] d, logic [63:0] v,
                                       logic [3:0] f, logic [63:0] pc, logic [1:0] s);
        t_result r;
        r.reg_write = w; r.dest_index = d; r.write_value = v;
        r.flags = f; r.next_pc = pc; r.status = s;
        return r;
    endfunction

    function automatic void add_row(logic [1:0] f, logic [31:0] insn, bit known = 0,
                                    t_result r = '0);
        t_row x;
        x.word = {f, insn};
        x.known = known;
        x.res = r;
        rows.push_back(x);
    endfunction

    // Random instruction biased toward decodable forms.
    function automatic t_word rand_word();
        t_word t;
        logic [31:0] w;
        int pick;
        w = $urandom;
        pick = $urandom_range(0, 19);
        // keep register numbers mostly small so values chain
        if ($urandom_range(0, 3) != 0) begin
            w[4:0] = 5'($urandom_range(0, 7));
            w[9:5] = 5'($urandom_range(0, 7));
            w[20:16] = 5'($urandom_range(0, 7));
        end
        if (pick < 5) begin
            t.func = FUNC_DPI;
            w[28:23] = ($urandom_range(0, 1)) ? 6'b100010 : 6'b100101;
            if (pick == 0) w[28:23] = 6'($urandom);
        end else if (pick < 12) begin
            t.func = FUNC_DPR;
            if (pick < 10) begin
                w[28] = 1'b0;
                w[24] = 1'($urandom_range(0, 1));
                if (w[24]) w[21] = 1'b0;
                if (!w[31]) w[15] = 1'b0;
                if (pick == 9) w[15] = 1'($urandom);
            end else if (pick == 10) begin
                w[28] = 1'b1;
                w[24:21] = 4'd8;
            end
        end else if (pick < 19) begin
            t.func = FUNC_BR;
            if (pick < 17) begin
                w[31:30] = $urandom_range(0, 1) ? 2'd1 : ($urandom_range(0, 1) ? 2'd0 : 2'd3);
                if (w[31:30] != 2'd1 && $urandom_range(0, 1)) w[31:30] = 2'd1;
                if (w[31:30] == 2'd1 && $urandom_range(0, 7) != 0) begin
                    case ($urandom_range(0, 6))
                        0: w[3:0] = CC_EQ; 1: w[3:0] = CC_NE; 2: w[3:0] = CC_GE;
                        3: w[3:0] = CC_LT; 4: w[3:0] = CC_GT; 5: w[3:0] = CC_LE;
                        default: w[3:0] = CC_AL;
                    endcase
                end
            end
        end else begin
            t.func = 2'($urandom);
        end
        t.insn = w;
        return t;
    endfunction

    // Sender: one process drives every word, with random gaps.
    task automatic send_word(t_word wd, bit known, t_result r);
        int gap;
        if (!calm && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 12);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= wd.func;
        s_axis_tdata  <= wd.insn;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        // accepted at this edge
        if (known) begin
            pending_results.push_back(r);
            void'(execute_word(wd));
        end else begin
            pending_results.push_back(execute_word(wd));
        end
    endtask

    // Receiver: random stalls, one long hold on request.
    initial begin
        int n;
        @(posedge i_rst_n);
        forever begin
            if (hold_long) begin
                m_axis_tready <= 1'b0;
                n = 0;
                while (n < 60) begin
                    @(posedge i_clk);
                    n++;
                end
                hold_long = 1'b0;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    // Checker: compare each accepted result word against the oldest expectation.
    always @(posedge i_clk) begin
        t_result got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.reg_write   = m_axis_tdata[0];
            got.dest_index  = m_axis_tdata[5:1];
            got.write_value = m_axis_tdata[69:6];
            got.flags       = m_axis_tdata[73:70];
            got.next_pc     = m_axis_tdata[137:74];
            got.status      = m_axis_tdata[139:138];
            if (pending_results.size() == 0) begin
                $error("result word with nothing expected");
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (got.reg_write !== want.reg_write) begin
                    $error("reg_write exp %0h got %0h", want.reg_write, got.reg_write);
                    errors++;
                end
                if (got.dest_index !== want.dest_index) begin
                    $error("dest_index exp %0h got %0h", want.dest_index, got.dest_index);
                    errors++;
                end
                if (got.write_value !== want.write_value) begin
                    $error("write_value exp %0h got %0h", want.write_value, got.write_value);
                    errors++;
                end
                if (got.flags !== want.flags) begin
                    $error("flags_nzcv exp %0h got %0h", want.flags, got.flags);
                    errors++;
                end
                if (got.next_pc !== want.next_pc) begin
                    $error("next_pc exp %0h got %0h", want.next_pc, got.next_pc);
                    errors++;
                end
                if (got.status !== want.status) begin
                    $error("status exp %0h got %0h", want.status, got.status);
                    errors++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        t_word wd;
        int i;
        for (i = 0; i < NUM_REGS; i++) arch_regs[i] = '0;
        arch_flags = FLAGS_RESET;
        arch_pc = '0;

        // directed table
        add_row(FUNC_BR, 32'h8000_0000, 1, res_of(0, 0, 0, FLAGS_RESET, 0, ST_ENC));
        add_row(FUNC_BR, 32'hC000_03E0, 1, res_of(0, 0, 0, FLAGS_RESET, 0, ST_BRZR));
        add_row(2'd3, 32'hFFFF_FFFF, 1, res_of(0, 0, 0, FLAGS_RESET, 0, ST_ENC));
        add_row(FUNC_BR, 32'h4000_000F, 1, res_of(0, 0, 0, FLAGS_RESET, 0, ST_COND));
        add_row(FUNC_DPI, 32'hD280_0001, 1, res_of(1, 1, 0, FLAGS_RESET, 4, ST_OK));
        add_row(FUNC_DPI, 32'h92FF_FFE2, 1,
                res_of(1, 2, 64'h0000_FFFF_FFFF_FFFF, FLAGS_RESET, 8, ST_OK));
        add_row(FUNC_DPI, 32'h12C0_0003, 1, res_of(0, 0, 0, FLAGS_RESET, 8, ST_ENC));
        add_row(FUNC_DPI, 32'hB2A0_0003);                 // movz opc 1: error
        add_row(FUNC_DPI, 32'hF29F_FFE3);                 // movk hw0
        add_row(FUNC_DPI, 32'hF1FF_FC24);                 // subs x4, x1, #fff lsl 12 with bit 23 set: error
        add_row(FUNC_DPI, 32'h3100_045F);                 // adds wzr, w2, #1
        add_row(FUNC_DPR, 32'hAB82_FC65);                 // adds asr 63
        add_row(FUNC_DPR, 32'h2B02_8065);                 // 32-bit amt 32: error
        add_row(FUNC_DPR, 32'h8BC2_0066);                 // add ror by zero
        add_row(FUNC_DPR, 32'hCBC2_1066);                 // sub ror 4
        add_row(FUNC_DPR, 32'hEA62_0867);                 // bics lsr 2
        add_row(FUNC_DPR, 32'hAA22_0468);                 // orn
        add_row(FUNC_DPR, 32'hCA42_0C69);                 // eor lsr
        add_row(FUNC_DPR, 32'h9B02_1C6A);                 // madd
        add_row(FUNC_DPR, 32'h7B02_9C6B);                 // msub w, opc ignored
        add_row(FUNC_DPR, 32'h9A02_006B);                 // other group: error
        add_row(FUNC_BR, 32'h4000_004D);                  // b.le
        add_row(FUNC_BR, 32'h03FF_FFFF);                  // b -4
        add_row(FUNC_BR, 32'h5FFF_FFEC);                  // b.gt back
        add_row(FUNC_BR, 32'hC000_0080);                  // br x4

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[k]) send_word(rows[k].word, rows[k].known, rows[k].res);

        // random streams; midway pressure and a full drain
        for (i = 0; i < N_RANDOM; i++) begin
            if (i == 400) hold_long = 1'b1;
            if (i == 800) begin
                s_axis_tvalid <= 1'b0;
                while (pending_results.size() != 0) @(posedge i_clk);
            end
            if (i == N_RANDOM - 200) calm = 1'b1;
            wd = rand_word();
            send_word(wd, 0, '0);
        end
        s_axis_tvalid <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

### filelist.f
sv/a64x_pkg.sv
sv/a64x_regfile.sv
sv/a64x_exec.sv
sv/aarch64_subset_execute_unit.sv
tb/sv/aarch64_subset_execute_unit_test.sv
